// ----- rtl/complex_fir_real_taps_macros.svh -----
// Assertion macros used by the filter controller.
`ifndef COMPLEX_FIR_REAL_TAPS_MACROS_SVH
`define COMPLEX_FIR_REAL_TAPS_MACROS_SVH
`ifndef ASSERT_OFF
`define CFIR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CFIR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CFIR_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define CFIR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/cfir_pkg.sv -----
// Shared types and constants of the complex FIR filter.
`timescale 1ns / 1ps
package cfir_pkg;
   localparam int TAP_COUNT_W = 7;
   localparam int COEF_INDEX_W = 6;
   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd1;

   localparam logic MODE_COEF   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic coef_we;
      logic sample_we;
      logic clear_acc;
      logic issue;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } status_type;
endpackage

// ----- rtl/cfir_ctrl.sv -----
// Controller: handshakes, tap loop sequencing and result valid.
`timescale 1ns / 1ps
`include "complex_fir_real_taps_macros.svh"
module cfir_ctrl #(
   parameter int MAX_TAPS = 64,
   parameter int AW = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cfir_pkg::TAP_COUNT_W-1:0] csr_tap_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cfir_pkg::cmd_type               cmd,
   output logic [AW-1:0]                   tap_idx,
   input  cfir_pkg::status_type            status
);
   import cfir_pkg::*;

   localparam int KW = $clog2(MAX_TAPS + 1);
   localparam int LW = (KW > TAP_COUNT_W) ? KW : TAP_COUNT_W;
   localparam logic [LW-1:0] MAX_L = LW'(MAX_TAPS);

   state_type state_ff, state_in;
   logic [AW-1:0] k_ff, k_in;
   logic [TAP_COUNT_W-1:0] tap_count_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0] tc_ext, taps;
   logic last_tap;

   assign tc_ext = LW'(tap_count_ff);
   assign taps = (tc_ext == '0) ? LW'(1) : ((tc_ext > MAX_L) ? MAX_L : tc_ext);
   assign last_tap = ((LW'(k_ff) + LW'(1)) == taps);

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign tap_idx = k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         tap_count_ff <= csr_tap_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_SAMPLE) begin
                  cmd.sample_we = 1'b1;
                  cmd.clear_acc = 1'b1;
                  k_in = '0;
                  state_in = ST_MAC;
               end else begin
                  cmd.coef_we = 1'b1;
               end
            end
         end
         ST_MAC: begin
            cmd.issue = 1'b1;
            k_in = k_ff + AW'(1);
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The result register may be reloaded in the cycle its word is taken.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `CFIR_ASSERT_NOW(a_load_free, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready)
   `CFIR_ASSERT_NOW(a_issue_range, clock, reset, cmd.issue, LW'(k_ff) < taps)
   `CFIR_ASSERT_NEXT(a_sample_starts, clock, reset,
      req_valid && req_ready && req_mode == MODE_SAMPLE, state_ff == ST_MAC)
   `CFIR_ASSERT_NOW(a_finish_drained, clock, reset, state_ff == ST_FINISH, !status.pipe_busy)
endmodule

// ----- rtl/cfir_datapath.sv -----
// Datapath: tap and history memories, multiply-accumulate pipe, round and saturate.
`timescale 1ns / 1ps
module cfir_datapath #(
   parameter int MAX_TAPS = 64,
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH = 16,
   parameter int AW = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cfir_pkg::cmd_type                     cmd,
   input  logic [AW-1:0]                         tap_idx,
   output cfir_pkg::status_type                  status,
   input  logic [cfir_pkg::COEF_INDEX_W-1:0]     req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]          req_coef_value,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample_re,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample_im,
   input  logic                                  req_start_of_block,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_out_re,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_out_im,
   output logic                                  rsp_overflow
);
   import cfir_pkg::*;

   localparam int FW = $clog2(MAX_TAPS + 1);
   localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_W = PW + AW + 1;
   localparam int XW = AW + COEF_INDEX_W;
   localparam logic [AW-1:0] LAST_A = AW'(MAX_TAPS - 1);
   localparam logic [AW:0] MAX_A = (AW + 1)'(MAX_TAPS);
   localparam logic [FW-1:0] MAX_F = FW'(MAX_TAPS);
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_WIDTH - 2);
   localparam logic signed [ACC_W-1:0] HI_L = ACC_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [ACC_W-1:0] LO_L = -HI_L - ACC_W'(1);

   logic signed [COEF_WIDTH-1:0] tap_mem [MAX_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] hre_mem [MAX_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] him_mem [MAX_TAPS];
   logic [MAX_TAPS-1:0] tap_vld_ff;

   logic [AW-1:0] wp_ff, wp_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [XW-1:0] cidx_ext;
   logic [AW-1:0] caddr;
   logic coef_ok;
   logic [AW:0] hsum;
   logic [AW-1:0] haddr;

   logic v1_ff, v2_ff;
   logic tvld1_ff, hvld1_ff;
   logic signed [COEF_WIDTH-1:0] tap1_ff;
   logic signed [SAMPLE_WIDTH-1:0] hre1_ff, him1_ff;
   logic signed [COEF_WIDTH-1:0] tap_op;
   logic signed [SAMPLE_WIDTH-1:0] hre_op, him_op;
   logic signed [PW-1:0] pre2_ff, pim2_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff;
   logic signed [ACC_W-1:0] sh_re, sh_im;
   logic ovf_re, ovf_im;

   assign cidx_ext = XW'(req_coef_index);
   assign caddr = cidx_ext[AW-1:0];
   assign coef_ok = (32'(req_coef_index) < 32'(MAX_TAPS));

   assign wp_in = (wp_ff == LAST_A) ? '0 : wp_ff + AW'(1);
   assign fill_in = req_start_of_block ? FW'(1)
                  : ((fill_ff == MAX_F) ? MAX_F : fill_ff + FW'(1));

   // Oldest samples sit behind the write pointer, wrapping around the ring.
   assign hsum = ({1'b0, wp_ff} >= {1'b0, tap_idx}) ? {1'b0, wp_ff} - {1'b0, tap_idx}
               : {1'b0, wp_ff} + MAX_A - {1'b0, tap_idx};
   assign haddr = hsum[AW-1:0];

   assign status.pipe_busy = v1_ff || v2_ff;

   always_ff @(posedge clock) begin
      if (cmd.coef_we && coef_ok) begin
         tap_mem[caddr] <= req_coef_value;
      end
      if (cmd.sample_we) begin
         hre_mem[wp_in] <= req_sample_re;
         him_mem[wp_in] <= req_sample_im;
      end
      tap1_ff <= tap_mem[tap_idx];
      hre1_ff <= hre_mem[haddr];
      him1_ff <= him_mem[haddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_vld_ff <= '0;
         wp_ff <= '0;
         fill_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (cmd.coef_we && coef_ok) begin
            tap_vld_ff[caddr] <= 1'b1;
         end
         if (cmd.sample_we) begin
            wp_ff <= wp_in;
            fill_ff <= fill_in;
         end
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      tvld1_ff <= tap_vld_ff[tap_idx];
      hvld1_ff <= (FW'(tap_idx) < fill_ff);
   end

   assign tap_op = tvld1_ff ? tap1_ff : '0;
   assign hre_op = hvld1_ff ? hre1_ff : '0;
   assign him_op = hvld1_ff ? him1_ff : '0;

   always_ff @(posedge clock) begin
      pre2_ff <= PW'(tap_op) * PW'(hre_op);
      pim2_ff <= PW'(tap_op) * PW'(him_op);
      if (cmd.clear_acc) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (v2_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(pre2_ff);
         acc_im_ff <= acc_im_ff + ACC_W'(pim2_ff);
      end
   end

   assign sh_re = (acc_re_ff + HALF) >>> (COEF_WIDTH - 1);
   assign sh_im = (acc_im_ff + HALF) >>> (COEF_WIDTH - 1);
   assign ovf_re = (sh_re > HI_L) || (sh_re < LO_L);
   assign ovf_im = (sh_im > HI_L) || (sh_im < LO_L);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_out_re <= (sh_re > HI_L) ? HI_L[SAMPLE_WIDTH-1:0]
                     : ((sh_re < LO_L) ? LO_L[SAMPLE_WIDTH-1:0] : sh_re[SAMPLE_WIDTH-1:0]);
         rsp_out_im <= (sh_im > HI_L) ? HI_L[SAMPLE_WIDTH-1:0]
                     : ((sh_im < LO_L) ? LO_L[SAMPLE_WIDTH-1:0] : sh_im[SAMPLE_WIDTH-1:0]);
         rsp_overflow <= ovf_re || ovf_im;
      end
   end
endmodule

// ----- rtl/complex_fir_real_taps.sv -----
// Top level of the complex-sample FIR filter with real taps.
// The req channel carries one word per item: mode 0 writes req_coef_value into
// tap req_coef_index and gives no result; mode 1 feeds one complex sample and
// gives one rsp word with the filtered value and an overflow flag. A sample
// with req_start_of_block set starts a new channel with an empty delay line.
// The csr channel writes the tap count; write it only while the block is idle.
// A coefficient word is written without leaving idle. A sample word walks the
// tap count in use (a count of zero works as one, any above MAX_TAPS as
// MAX_TAPS) through one shared multiply-accumulate unit, one tap per cycle,
// in a three-stage read, multiply and accumulate pipe; once the pipe drains,
// the result is loaded, and the next word can be taken in the cycle after that.
// The result sits in an output register, so the next sample is computed while
// an earlier word waits; a stalled receiver only holds the final load.
// Synchronous reset empties the delay line, zeroes all taps and sets the tap
// count to one; no clearing pass is needed.
`timescale 1ns / 1ps
module complex_fir_real_taps #(
   parameter int MAX_TAPS = 64,
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_mode,
   input  logic [cfir_pkg::COEF_INDEX_W-1:0]     req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]          req_coef_value,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample_re,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample_im,
   input  logic                                  req_start_of_block,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cfir_pkg::TAP_COUNT_W-1:0]      csr_tap_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_out_re,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_out_im,
   output logic                                  rsp_overflow
);
   import cfir_pkg::*;

   localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

   cmd_type cmd;
   status_type status;
   logic [AW-1:0] tap_idx;

   cfir_ctrl #(
      .MAX_TAPS(MAX_TAPS),
      .AW(AW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_tap_count(csr_tap_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd(cmd),
      .tap_idx(tap_idx),
      .status(status)
   );

   cfir_datapath #(
      .MAX_TAPS(MAX_TAPS),
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COEF_WIDTH(COEF_WIDTH),
      .AW(AW)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .tap_idx(tap_idx),
      .status(status),
      .req_coef_index(req_coef_index),
      .req_coef_value(req_coef_value),
      .req_sample_re(req_sample_re),
      .req_sample_im(req_sample_im),
      .req_start_of_block(req_start_of_block),
      .rsp_out_re(rsp_out_re),
      .rsp_out_im(rsp_out_im),
      .rsp_overflow(rsp_overflow)
   );
endmodule
